// ===== rtl/q2e_pkg.sv =====
// Shared types, constants and helper functions for the quaternion to Euler bucket pipeline.
package q2e_pkg;

  // Default configuration of the block.
  localparam int ANGLE_STEPS_DEF    = 18;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Arctangent pipeline geometry.
  localparam int CORDIC_ITERS = 28;
  localparam int NORM_STAGES  = 6;
  localparam int ATAN_LAT     = 1 + NORM_STAGES + CORDIC_ITERS + 1;

  // Square root pipeline: one result bit per cell.
  localparam int SQRT_STEPS = 32;

  // Operand and angle widths.
  localparam int OPW = 64;
  localparam int ANW = 34;

  // Binary angle landmarks (2^32 units per full turn).
  localparam logic signed [ANW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [ANW-1:0] QUARTER_TURN = 34'sd1073741824;

  // Normalisation target: the larger magnitude ends at or above this bit.
  localparam int NORM_BIT = 58;

  // Elementary arctangent angles, one per CORDIC iteration.
  localparam logic signed [ANW-1:0] ATAN_TABLE [0:CORDIC_ITERS-1] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
    34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
    34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5
  };

  // Side information that travels with each vector through the CORDIC chain.
  typedef struct packed {
    logic zero_y;
    logic neg_x;
  } q2e_side_t;

  // Magnitude of a signed operand.
  function automatic logic [OPW-1:0] mag64(input logic signed [OPW-1:0] v);
    logic [OPW-1:0] r;
    r = v[OPW-1] ? OPW'(-v) : OPW'(v);
    return r;
  endfunction

endpackage

// ===== rtl/q2e_sqrt_cell.sv =====
// One cell of the integer square root chain: settles one result bit per cycle.
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic [q2e_pkg::OPW-1:0]           rem_in,
  input  logic [q2e_pkg::OPW-1:0]           root_in,
  input  logic signed [31:0]                sin_in,
  output logic [q2e_pkg::OPW-1:0]           rem,
  output logic [q2e_pkg::OPW-1:0]           root,
  output logic signed [31:0]                sin
);

  localparam logic [q2e_pkg::OPW-1:0] BIT = q2e_pkg::OPW'(1) << (62 - 2 * STEP);

  logic [q2e_pkg::OPW-1:0] trial;
  logic [q2e_pkg::OPW-1:0] rem_next;
  logic [q2e_pkg::OPW-1:0] root_next;

  // Trial subtraction of the current root plus this step's bit.
  always_comb begin
    trial = root_in + BIT;
    if (rem_in >= trial) begin
      rem_next  = rem_in - trial;
      root_next = (root_in >> 1) + BIT;
    end else begin
      rem_next  = rem_in;
      root_next = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    root <= root_next;
    sin  <= sin_in;
  end

endmodule

// ===== rtl/q2e_cordic_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation towards the x axis.
module q2e_cordic_cell #(
  parameter int ITER = 0
) (
  input  logic                              clk,
  input  logic signed [q2e_pkg::OPW-1:0]    x_in,
  input  logic signed [q2e_pkg::OPW-1:0]    y_in,
  input  logic signed [q2e_pkg::ANW-1:0]    ang_in,
  input  q2e_pkg::q2e_side_t                side_in,
  output logic signed [q2e_pkg::OPW-1:0]    x,
  output logic signed [q2e_pkg::OPW-1:0]    y,
  output logic signed [q2e_pkg::ANW-1:0]    ang,
  output q2e_pkg::q2e_side_t                side
);

  logic signed [q2e_pkg::OPW-1:0] dx;
  logic signed [q2e_pkg::OPW-1:0] dy;
  logic signed [q2e_pkg::OPW-1:0] x_next;
  logic signed [q2e_pkg::OPW-1:0] y_next;
  logic signed [q2e_pkg::ANW-1:0] ang_next;

  // Rotate by the elementary angle in the direction that shrinks y.
  always_comb begin
    dx = y_in >>> ITER;
    dy = x_in >>> ITER;
    if (y_in > 0) begin
      x_next   = x_in + dx;
      y_next   = y_in - dy;
      ang_next = ang_in + q2e_pkg::ATAN_TABLE[ITER];
    end else begin
      x_next   = x_in - dx;
      y_next   = y_in + dy;
      ang_next = ang_in - q2e_pkg::ATAN_TABLE[ITER];
    end
  end

  always_ff @(posedge clk) begin
    x    <= x_next;
    y    <= y_next;
    ang  <= ang_next;
    side <= side_in;
  end

endmodule

// ===== rtl/q2e_atan2.sv =====
// Pipelined two-argument arctangent: quadrant fold, normalisation and a chain of CORDIC cells.
module q2e_atan2 (
  input  logic                              clk,
  input  logic signed [q2e_pkg::OPW-1:0]    y_in,
  input  logic signed [q2e_pkg::OPW-1:0]    x_in,
  output logic signed [q2e_pkg::ANW-1:0]    ang
);

  localparam int NS = q2e_pkg::NORM_STAGES;
  localparam int NI = q2e_pkg::CORDIC_ITERS;

  logic signed [q2e_pkg::OPW-1:0] nx [0:NS];
  logic signed [q2e_pkg::OPW-1:0] ny [0:NS];
  logic [q2e_pkg::OPW-1:0]        nm [0:NS];
  logic signed [q2e_pkg::ANW-1:0] na [0:NS];
  q2e_pkg::q2e_side_t             ns [0:NS];

  logic signed [q2e_pkg::OPW-1:0] cx [0:NI];
  logic signed [q2e_pkg::OPW-1:0] cy [0:NI];
  logic signed [q2e_pkg::ANW-1:0] ca [0:NI];
  q2e_pkg::q2e_side_t             cs [0:NI];

  logic signed [q2e_pkg::OPW-1:0] fx;
  logic signed [q2e_pkg::OPW-1:0] fy;
  logic signed [q2e_pkg::ANW-1:0] fa;
  logic signed [q2e_pkg::ANW-1:0] ang_next;

  // Fold the left half plane onto the right half by a quarter turn.
  always_comb begin
    fx = x_in;
    fy = y_in;
    fa = '0;
    if (x_in < 0) begin
      if (y_in > 0) begin
        fx = y_in;
        fy = -x_in;
        fa = q2e_pkg::QUARTER_TURN;
      end else begin
        fx = -y_in;
        fy = x_in;
        fa = -q2e_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    nx[0]        <= fx;
    ny[0]        <= fy;
    nm[0]        <= q2e_pkg::mag64(fx) | q2e_pkg::mag64(fy);
    na[0]        <= fa;
    ns[0].zero_y <= (y_in == 0);
    ns[0].neg_x  <= (x_in < 0);
  end

  // Binary search normalisation: shift by 32, 16, 8, 4, 2 and 1 where room allows.
  for (genvar k = 1; k <= NS; k++) begin : g_norm
    localparam int SH = 1 << (NS - k);
    localparam logic [q2e_pkg::OPW-1:0] LIM =
      q2e_pkg::OPW'(1) << (q2e_pkg::NORM_BIT + 1 - SH);
    always_ff @(posedge clk) begin
      if (nm[k-1] < LIM) begin
        nx[k] <= nx[k-1] <<< SH;
        ny[k] <= ny[k-1] <<< SH;
        nm[k] <= nm[k-1] << SH;
      end else begin
        nx[k] <= nx[k-1];
        ny[k] <= ny[k-1];
        nm[k] <= nm[k-1];
      end
      na[k] <= na[k-1];
      ns[k] <= ns[k-1];
    end
  end

  assign cx[0] = nx[NS];
  assign cy[0] = ny[NS];
  assign ca[0] = na[NS];
  assign cs[0] = ns[NS];

  // Chain of micro-rotation cells.
  for (genvar i = 0; i < NI; i++) begin : g_cell
    q2e_cordic_cell #(.ITER(i)) u_cell (
      .clk     (clk),
      .x_in    (cx[i]),
      .y_in    (cy[i]),
      .ang_in  (ca[i]),
      .side_in (cs[i]),
      .x       (cx[i+1]),
      .y       (cy[i+1]),
      .ang     (ca[i+1]),
      .side    (cs[i+1])
    );
  end

  // A vector on the x axis bypasses the rotations; otherwise clamp to half a turn.
  always_comb begin
    if (cs[NI].zero_y) begin
      ang_next = cs[NI].neg_x ? q2e_pkg::HALF_TURN : '0;
    end else if (ca[NI] > q2e_pkg::HALF_TURN) begin
      ang_next = q2e_pkg::HALF_TURN;
    end else if (ca[NI] < -q2e_pkg::HALF_TURN) begin
      ang_next = -q2e_pkg::HALF_TURN;
    end else begin
      ang_next = ca[NI];
    end
  end

  always_ff @(posedge clk) begin
    ang <= ang_next;
  end

endmodule

// ===== rtl/quaternion_to_euler_buckets.sv =====
// Top level: quaternion to roll, pitch and yaw buckets.
// A quaternion beat is taken on any cycle with start high; busy is always low, so one beat
// per cycle is sustained. Each beat gives one result, shown with done high for a single
// cycle. The receiver cannot stall it, so it must capture the result in that cycle. The
// pitch path is the longest: an input register, a product register, a sum register, a
// squaring register, a 32-cell square root chain, the 36-stage arctangent pipeline and a
// bucket register. Roll and yaw finish earlier and are delayed to line up.
module quaternion_to_euler_buckets #(
  parameter int ANGLE_STEPS    = q2e_pkg::ANGLE_STEPS_DEF,
  parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic [4:0]         roll_bucket,
  output logic [4:0]         pitch_bucket,
  output logic [4:0]         yaw_bucket
);

  localparam int OPW   = q2e_pkg::OPW;
  localparam int ANW   = q2e_pkg::ANW;
  localparam int NSQ   = q2e_pkg::SQRT_STEPS;
  localparam int SKEW  = 1 + NSQ;
  localparam int LAT   = 3 + 1 + NSQ + q2e_pkg::ATAN_LAT + 1;
  localparam int PW    = ANW + 8;
  localparam logic signed [OPW-1:0] ONE = OPW'(1) <<< (2 * QUAT_FRAC_BITS);

  logic [LAT-1:0] vld;

  logic signed [15:0] w_q, x_q, y_q, z_q;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;

  logic signed [OPW-1:0] rn_c, rd_c, yn_c, yd_c, s_c, sc_c;
  logic signed [31:0]    s30_c;
  logic signed [OPW-1:0] rn, rd, yn, yd;
  logic signed [31:0]    s30;

  logic [30:0]     s_mag;
  logic [OPW-1:0]  sq_rem [0:NSQ];
  logic [OPW-1:0]  sq_root [0:NSQ];
  logic signed [31:0] sq_sin [0:NSQ];

  logic signed [ANW-1:0] roll_ang, yaw_ang, pitch_ang;
  logic signed [ANW-1:0] pitch_cl;
  logic [ANW-1:0]        roll_u, yaw_u, pitch_u;
  logic [PW-1:0]         roll_p, yaw_p, pitch_p;
  logic [4:0]            roll_b, yaw_b;
  logic [4:0]            roll_dly [0:SKEW-1];
  logic [4:0]            yaw_dly [0:SKEW-1];

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // Beat tracking: one valid bit per pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // Input register and component products.
  always_ff @(posedge clk) begin
    w_q  <= quat_w;
    x_q  <= quat_x;
    y_q  <= quat_y;
    z_q  <= quat_z;
    p_wx <= w_q * x_q;
    p_yz <= y_q * z_q;
    p_xx <= x_q * x_q;
    p_yy <= y_q * y_q;
    p_wz <= w_q * z_q;
    p_xy <= x_q * y_q;
    p_zz <= z_q * z_q;
    p_wy <= w_q * y_q;
    p_zx <= z_q * x_q;
  end

  // Arctangent operands and the clamped arcsine argument.
  always_comb begin
    rn_c = OPW'(2) * (OPW'(p_wx) + OPW'(p_yz));
    rd_c = ONE - OPW'(2) * (OPW'(p_xx) + OPW'(p_yy));
    yn_c = OPW'(2) * (OPW'(p_wz) + OPW'(p_xy));
    yd_c = ONE - OPW'(2) * (OPW'(p_yy) + OPW'(p_zz));
    s_c  = OPW'(2) * (OPW'(p_wy) - OPW'(p_zx));
    if (s_c > ONE) begin
      sc_c = ONE;
    end else if (s_c < -ONE) begin
      sc_c = -ONE;
    end else begin
      sc_c = s_c;
    end
  end

  // Rescale the arcsine argument to 30 fraction bits.
  if (2 * QUAT_FRAC_BITS >= 30) begin : g_s30_down
    assign s30_c = 32'(sc_c >>> (2 * QUAT_FRAC_BITS - 30));
  end else begin : g_s30_up
    assign s30_c = 32'(sc_c <<< (30 - 2 * QUAT_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    rn  <= rn_c;
    rd  <= rd_c;
    yn  <= yn_c;
    yd  <= yd_c;
    s30 <= s30_c;
  end

  // Radicand for the cosine of pitch: 2^60 minus the squared sine.
  assign s_mag = 31'(q2e_pkg::mag64(OPW'(s30)));

  always_ff @(posedge clk) begin
    sq_rem[0]  <= (OPW'(1) << 60) - OPW'(s_mag) * OPW'(s_mag);
    sq_root[0] <= '0;
    sq_sin[0]  <= s30;
  end

  // Square root chain, one result bit per cell.
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    q2e_sqrt_cell #(.STEP(j)) u_sqrt (
      .clk     (clk),
      .rem_in  (sq_rem[j]),
      .root_in (sq_root[j]),
      .sin_in  (sq_sin[j]),
      .rem     (sq_rem[j+1]),
      .root    (sq_root[j+1]),
      .sin     (sq_sin[j+1])
    );
  end

  // Three arctangent pipelines.
  q2e_atan2 u_roll (
    .clk  (clk),
    .y_in (rn),
    .x_in (rd),
    .ang  (roll_ang)
  );

  q2e_atan2 u_yaw (
    .clk  (clk),
    .y_in (yn),
    .x_in (yd),
    .ang  (yaw_ang)
  );

  q2e_atan2 u_pitch (
    .clk  (clk),
    .y_in (OPW'(sq_sin[NSQ])),
    .x_in ({32'd0, sq_root[NSQ][31:0]}),
    .ang  (pitch_ang)
  );

  // Bucket scaling: clamp pitch, offset to unsigned, scale by the step count, keep the top.
  always_comb begin
    if (pitch_ang > q2e_pkg::QUARTER_TURN) begin
      pitch_cl = q2e_pkg::QUARTER_TURN;
    end else if (pitch_ang < -q2e_pkg::QUARTER_TURN) begin
      pitch_cl = -q2e_pkg::QUARTER_TURN;
    end else begin
      pitch_cl = pitch_ang;
    end
    roll_u  = ANW'(roll_ang + q2e_pkg::HALF_TURN);
    yaw_u   = ANW'(yaw_ang + q2e_pkg::HALF_TURN);
    pitch_u = ANW'(pitch_cl + q2e_pkg::QUARTER_TURN);
    roll_p  = PW'(roll_u) * PW'(8'(ANGLE_STEPS));
    yaw_p   = PW'(yaw_u) * PW'(8'(ANGLE_STEPS));
    pitch_p = PW'(pitch_u) * PW'(8'(ANGLE_STEPS));
  end

  always_ff @(posedge clk) begin
    roll_b       <= roll_p[36:32];
    yaw_b        <= yaw_p[36:32];
    pitch_bucket <= pitch_p[35:31];
  end

  // Delay roll and yaw to meet the longer pitch path.
  always_ff @(posedge clk) begin
    roll_dly[0] <= roll_b;
    yaw_dly[0]  <= yaw_b;
    for (int k = 1; k < SKEW; k++) begin
      roll_dly[k] <= roll_dly[k-1];
      yaw_dly[k]  <= yaw_dly[k-1];
    end
  end

  assign roll_bucket = roll_dly[SKEW-1];
  assign yaw_bucket  = yaw_dly[SKEW-1];

endmodule

// ===== verif/quaternion_to_euler_buckets_test.sv =====
// Self-checking testbench for the quaternion to Euler bucket pipeline.
module quaternion_to_euler_buckets_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_STEPS = q2e_pkg::ANGLE_STEPS_DEF;
  localparam int FRAC_BITS   = q2e_pkg::QUAT_FRAC_BITS_DEF;
  localparam int ITERS       = q2e_pkg::CORDIC_ITERS;
  localparam int LATENCY     = 73;
  localparam longint CYCLE_LIMIT = 200000;
  localparam longint HALF_T  = longint'(1) << 31;
  localparam longint QUART_T = longint'(1) << 30;

  typedef struct {
    logic [4:0] roll;
    logic [4:0] pitch;
    logic [4:0] yaw;
  } buckets_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic [4:0] roll_bucket, pitch_bucket, yaw_bucket;

  buckets_t pending_buckets[$];
  int error_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  longint cycle_count = 0;

  quaternion_to_euler_buckets dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .roll_bucket(roll_bucket), .pitch_bucket(pitch_bucket),
    .yaw_bucket(yaw_bucket)
  );

  // Free-running clock with a 10 ns period.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Floor division by a power of two.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint abs_val(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC: binary angle of (x, y), 2^32 units per turn.
  function automatic longint cordic_angle(longint y, longint x);
    longint ang, t, dx, dy;
    longint unsigned m;
    ang = 0;
    if (y == 0) return x < 0 ? HALF_T : 0;
    if (x < 0) begin
      if (y > 0) begin
        t = x; x = y; y = -t; ang = QUART_T;
      end else begin
        t = x; x = -y; y = t; ang = -QUART_T;
      end
    end
    m = abs_val(x) | abs_val(y);
    while (m < (64'd1 << 58)) begin
      x = x * 2; y = y * 2; m = m << 1;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(q2e_pkg::ATAN_TABLE[i]);
      end else begin
        x -= dx; y += dy; ang -= longint'(q2e_pkg::ATAN_TABLE[i]);
      end
    end
    if (ang > HALF_T) ang = HALF_T;
    if (ang < -HALF_T) ang = -HALF_T;
    return ang;
  endfunction

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Map a full-turn angle to its bucket.
  function automatic logic [4:0] turn_bucket(longint ang);
    longint unsigned u;
    u = longint'(ang + HALF_T);
    return 5'((u * ANGLE_STEPS) >> 32);
  endfunction

  // Expected roll, pitch and yaw buckets of one quaternion.
  function automatic buckets_t euler_buckets(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz);
    buckets_t b;
    longint w, x, y, z, one, rn, rd, yn, yd, s, s30, pang;
    longint unsigned c, u;
    w = qw; x = qx; y = qy; z = qz;
    one = longint'(1) << (2 * FRAC_BITS);
    rn = 2 * (w * x + y * z);
    rd = one - 2 * (x * x + y * y);
    yn = 2 * (w * z + x * y);
    yd = one - 2 * (y * y + z * z);
    s = 2 * (w * y - z * x);
    if (s > one) s = one;
    if (s < -one) s = -one;
    if (2 * FRAC_BITS >= 30) s30 = floor_shift(s, 2 * FRAC_BITS - 30);
    else s30 = s * (longint'(1) << (30 - 2 * FRAC_BITS));
    c = int_sqrt((64'd1 << 60) - abs_val(s30) * abs_val(s30));
    pang = cordic_angle(s30, longint'(c));
    if (pang > QUART_T) pang = QUART_T;
    if (pang < -QUART_T) pang = -QUART_T;
    u = pang + QUART_T;
    b.roll = turn_bucket(cordic_angle(rn, rd));
    b.pitch = 5'((u * ANGLE_STEPS) >> 31);
    b.yaw = turn_bucket(cordic_angle(yn, yd));
    return b;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("Mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin
    buckets_t want;
    if (!rst && done) begin
      if (pending_buckets.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_buckets.pop_front();
        if (roll_bucket !== want.roll) report_mismatch("roll", roll_bucket, want.roll);
        if (pitch_bucket !== want.pitch) report_mismatch("pitch", pitch_bucket, want.pitch);
        if (yaw_bucket !== want.yaw) report_mismatch("yaw", yaw_bucket, want.yaw);
      end
      results_seen++;
    end
  end

  // Present one quaternion and hold it until a beat is taken.
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    start <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    do @(posedge clk); while (busy);
    pending_buckets.insert(pending_buckets.size(), euler_buckets(w, x, y, z));
    beats_sent++;
  endtask

  // Drop start once a burst is over, then idle; a zero gap keeps start high.
  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_component();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Axis points, extremes and the special cases of the angle maths.
  task automatic test_directed();
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, -16384, 0);
    send_quat(0, 0, 0, -16384);
    send_quat(0, 0, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 11585, 11585, 11585);
    send_quat(16384, 0, 16384, 0);
    send_quat(-16384, 16384, 16384, -16384);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_quat(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    send_quat(1, -1, 1, -1);
    idle_cycles(1);
  endtask

  // Bursts of random unit-range quaternions with occasional raw bit patterns.
  task automatic test_random(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(9) == 0)
          send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_quat(rand_component(), rand_component(), rand_component(), rand_component());
        sent++;
      end
      idle_cycles($urandom_range(0, 6));
    end
  endtask

  // Wait until every expected beat has arrived, then for the pipeline to settle.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain_pipeline();
    test_random(200);
    drain_pipeline();
    test_random(200);
    drain_pipeline();
    $display("Sent %0d quaternion beats and checked %0d bucket results,", beats_sent,
             results_seen);
    $display("covering axis points, saturated pitch and random bursts with gaps.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== quaternion_to_euler_buckets.f =====
rtl/q2e_pkg.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/q2e_atan2.sv
rtl/quaternion_to_euler_buckets.sv
verif/quaternion_to_euler_buckets_test.sv
